// File: sv/knnls_pkg.sv
`default_nettype none

package knnls_pkg;

    localparam int LAT_W   = 28;
    localparam int LON_W   = 29;
    localparam int TAG_W   = 32;
    localparam int SQD_W   = 58;
    localparam int DIST_W  = 59;
    localparam int FUNC_W  = 2;
    localparam int CFG_W   = 5;
    localparam int ENTRY_W = LAT_W + LON_W + TAG_W;
    localparam int S_DATA_W = 96;
    localparam int M_DATA_W = 152;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_CLEAR  = 2'd0,
        FUNC_APPEND = 2'd1,
        FUNC_QUERY  = 2'd2,
        FUNC_NONE   = 2'd3
    } func_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EMPTY,
        S_SCAN_RD,
        S_SCAN_CAP,
        S_BS_RD,
        S_BS_CMP,
        S_SW_LRD,
        S_SW_LCAP,
        S_SW_RCAP,
        S_PICK,
        S_DIFF,
        S_SQ,
        S_SUM,
        S_INS,
        S_OUT_RD,
        S_OUT_EMIT
    } state_t;

    typedef struct packed {
        logic clear;
        logic insert;
        logic pop;
    } list_cmd_t;

endpackage

`default_nettype wire

// File: sv/knn_latitude_sweep_search.sv
// k nearest neighbor search over a latitude-sorted point list.
// s_ channel: s_tuser is the function (clear, append, query), s_tdata holds
// latitude, longitude and tag. Points must be appended in ascending latitude.
// m_ channel: one word per reported neighbor, nearest first, tlast on the
// final one; tuser is the found flag, low on the single word of an empty list.
// cfg_we/cfg_wdata write k, taken as 1 when zero and capped at MAX_NEIGHBORS.
// Clear and append are taken in the idle state. A query binary-searches the
// latitudes, loads the sweep with the points on both sides, then takes points
// one by one from the side nearer in latitude until the latitude gap alone
// cannot beat the worst kept distance (with points <= k the whole list is
// scanned), then emits the results, paced by the single-port point memory and
// the kept-list insertion. s_tready is high only between queries; the next word is
// taken while the final result still sits in the output register.
// A stalled receiver holds the result register and the sequencer waits.
// Reset empties the point list and sets k to 1; memory contents are kept.
`default_nettype none

module knn_latitude_sweep_search
    import knnls_pkg::*;
#(
    parameter int MAX_POINTS = 1024,
    parameter int MAX_NEIGHBORS = 16
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_W-1:0]     cfg_wdata,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_DATA_W-1:0]  s_tdata,   // latitude, longitude, point_tag
    input  wire logic [FUNC_W-1:0]    s_tuser,   // func
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_DATA_W-1:0]       m_tdata,   // tag, latitude, longitude, distance
    output logic                      m_tuser,   // found
    output logic                      m_tlast
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int KW = $clog2(MAX_NEIGHBORS + 1);

    state_t state_reg, state_next;

    logic [ENTRY_W-1:0] mem [MAX_POINTS];
    logic [ENTRY_W-1:0] mem_q;
    logic [AW-1:0]      rd_addr;

    logic [CFG_W-1:0]  ncount_reg;
    logic [KW-1:0]     k_reg, k_next, k_calc;
    logic [AW:0]       total_reg, total_next;
    logic [LAT_W-1:0]  q_lat_reg, q_lat_next;
    logic [LON_W-1:0]  q_lon_reg, q_lon_next;
    logic [AW-1:0]     l_reg, l_next;
    logic [AW:0]       r_reg, r_next;
    logic [AW-1:0]     mid_reg, mid_next, mid_calc;
    logic [AW:0]       mid_sum;
    logic              l_ok_reg, l_ok_next;
    logic              took_left_reg, took_left_next;
    logic              scan_reg, scan_next;
    logic [LAT_W-1:0]  cl_lat_reg, cl_lat_next, cr_lat_reg, cr_lat_next;
    logic [LON_W-1:0]  cl_lon_reg, cl_lon_next, cr_lon_reg, cr_lon_next;
    logic [LAT_W-1:0]  p_lat_reg, p_lat_next;
    logic [LON_W-1:0]  p_lon_reg, p_lon_next;
    logic [AW-1:0]     p_pos_reg, p_pos_next;
    logic [LAT_W-1:0]  da_reg, da_next;
    logic [LON_W-1:0]  db_reg, db_next;
    logic [2*LAT_W-1:0] sqa_reg, sqa_next;
    logic [2*LON_W-1:0] sqb_reg, sqb_next;
    logic [DIST_W-1:0] dist_reg, dist_next;

    logic                m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic                m_tuser_reg, m_tuser_next;
    logic                m_tlast_reg, m_tlast_next;

    logic [LAT_W-1:0]  s_lat, mem_lat;
    logic [LON_W-1:0]  s_lon, mem_lon;
    logic [TAG_W-1:0]  s_tag, mem_tag;
    func_t             s_func;
    logic              accept_in, out_free, r_ok, take_left, stop;
    logic [LAT_W-1:0]  gap_l, gap_r;
    logic [SQD_W-1:0]  sat_dist;

    list_cmd_t         lcmd;
    logic [KW-1:0]     list_kept;
    logic [DIST_W-1:0] worst_dist, head_dist;
    logic [AW-1:0]     head_pos;

    function automatic logic [LAT_W-1:0] abs_lat(input logic [LAT_W-1:0] a,
                                                 input logic [LAT_W-1:0] b);
        logic [LAT_W:0] d;
        d = {a[LAT_W-1], a} - {b[LAT_W-1], b};
        return d[LAT_W] ? LAT_W'(-d) : d[LAT_W-1:0];
    endfunction

    function automatic logic [LON_W-1:0] abs_lon(input logic [LON_W-1:0] a,
                                                 input logic [LON_W-1:0] b);
        logic [LON_W:0] d;
        d = {a[LON_W-1], a} - {b[LON_W-1], b};
        return d[LON_W] ? LON_W'(-d) : d[LON_W-1:0];
    endfunction

    assign s_lat   = s_tdata[LAT_W-1:0];
    assign s_lon   = s_tdata[LAT_W+LON_W-1:LAT_W];
    assign s_tag   = s_tdata[ENTRY_W-1:LAT_W+LON_W];
    assign s_func  = func_t'(s_tuser);
    assign mem_lat = mem_q[LAT_W-1:0];
    assign mem_lon = mem_q[LAT_W+LON_W-1:LAT_W];
    assign mem_tag = mem_q[ENTRY_W-1:LAT_W+LON_W];

    assign s_tready  = (state_reg == S_IDLE);
    assign accept_in = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;
    assign m_tlast   = m_tlast_reg;

    assign mid_sum  = {1'b0, l_reg} + r_reg + (AW+1)'(1);
    assign mid_calc = mid_sum[AW:1];
    assign r_ok     = r_reg < total_reg;
    assign gap_l    = abs_lat(cl_lat_reg, q_lat_reg);
    assign gap_r    = abs_lat(cr_lat_reg, q_lat_reg);
    assign take_left = !r_ok || (l_ok_reg && (gap_l < gap_r));
    assign stop     = !scan_reg && (list_kept >= k_reg)
                      && ({{(DIST_W-2*LAT_W){1'b0}}, sqa_reg} >= worst_dist);
    assign sat_dist = head_dist[DIST_W-1] ? {SQD_W{1'b1}} : head_dist[SQD_W-1:0];

    always_comb begin
        if (ncount_reg == '0) begin
            k_calc = KW'(1);
        end else if (int'(ncount_reg) > MAX_NEIGHBORS) begin
            k_calc = KW'(MAX_NEIGHBORS);
        end else begin
            k_calc = KW'(ncount_reg);
        end
    end

    always_comb begin
        unique case (state_reg)
            S_BS_RD:    rd_addr = mid_calc;
            S_SW_LCAP:  rd_addr = r_reg[AW-1:0];
            S_PICK:     rd_addr = take_left ? (l_reg - AW'(1)) : AW'(r_reg + (AW+1)'(1));
            S_OUT_RD,
            S_OUT_EMIT: rd_addr = head_pos;
            default:    rd_addr = l_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (accept_in && (s_func == FUNC_APPEND) && (total_reg < (AW+1)'(MAX_POINTS))) begin
            mem[total_reg[AW-1:0]] <= {s_tag, s_lon, s_lat};
        end
        mem_q <= mem[rd_addr];
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept_in && (s_func == FUNC_QUERY)) begin
                    if (total_reg == '0) begin
                        state_next = S_EMPTY;
                    end else if (32'(total_reg) <= 32'(k_calc)) begin
                        state_next = S_SCAN_RD;
                    end else begin
                        state_next = S_BS_RD;
                    end
                end
            end
            S_EMPTY:    if (out_free) state_next = S_IDLE;
            S_SCAN_RD:  state_next = S_SCAN_CAP;
            S_SCAN_CAP: state_next = S_DIFF;
            S_BS_RD:    state_next = ({1'b0, l_reg} < r_reg) ? S_BS_CMP : S_SW_LRD;
            S_BS_CMP:   state_next = S_BS_RD;
            S_SW_LRD:   state_next = S_SW_LCAP;
            S_SW_LCAP:  state_next = r_ok ? S_SW_RCAP : S_PICK;
            S_SW_RCAP:  state_next = S_PICK;
            S_PICK:     state_next = (l_ok_reg || r_ok) ? S_DIFF : S_OUT_RD;
            S_DIFF:     state_next = S_SQ;
            S_SQ:       state_next = S_SUM;
            S_SUM:      state_next = stop ? S_OUT_RD : S_INS;
            S_INS: begin
                if (!scan_reg) begin
                    state_next = S_PICK;
                end else if (({1'b0, l_reg} + (AW+1)'(1)) < total_reg) begin
                    state_next = S_SCAN_RD;
                end else begin
                    state_next = S_OUT_RD;
                end
            end
            S_OUT_RD:   state_next = S_OUT_EMIT;
            S_OUT_EMIT: begin
                if (out_free) state_next = (list_kept == KW'(1)) ? S_IDLE : S_OUT_RD;
            end
            default:    state_next = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        k_next = k_reg;
        total_next = total_reg;
        q_lat_next = q_lat_reg;
        q_lon_next = q_lon_reg;
        l_next = l_reg;
        r_next = r_reg;
        mid_next = mid_reg;
        l_ok_next = l_ok_reg;
        took_left_next = took_left_reg;
        scan_next = scan_reg;
        cl_lat_next = cl_lat_reg;
        cl_lon_next = cl_lon_reg;
        cr_lat_next = cr_lat_reg;
        cr_lon_next = cr_lon_reg;
        p_lat_next = p_lat_reg;
        p_lon_next = p_lon_reg;
        p_pos_next = p_pos_reg;
        da_next = da_reg;
        db_next = db_reg;
        sqa_next = sqa_reg;
        sqb_next = sqb_reg;
        dist_next = dist_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next = m_tdata_reg;
        m_tuser_next = m_tuser_reg;
        m_tlast_next = m_tlast_reg;
        lcmd = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (accept_in) begin
                    unique case (s_func)
                        FUNC_CLEAR: total_next = '0;
                        FUNC_APPEND: begin
                            if (total_reg < (AW+1)'(MAX_POINTS)) begin
                                total_next = total_reg + (AW+1)'(1);
                            end
                        end
                        FUNC_QUERY: begin
                            q_lat_next = s_lat;
                            q_lon_next = s_lon;
                            k_next = k_calc;
                            scan_next = 32'(total_reg) <= 32'(k_calc);
                            l_next = '0;
                            r_next = total_reg - (AW+1)'(1);
                            lcmd.clear = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            S_EMPTY: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next = '0;
                    m_tuser_next = 1'b0;
                    m_tlast_next = 1'b1;
                end
            end
            S_SCAN_CAP: begin
                p_lat_next = mem_lat;
                p_lon_next = mem_lon;
                p_pos_next = l_reg;
            end
            S_BS_RD: begin
                if ({1'b0, l_reg} < r_reg) begin
                    mid_next = mid_calc;
                end else begin
                    r_next = {1'b0, l_reg} + (AW+1)'(1);
                    l_ok_next = 1'b1;
                end
            end
            S_BS_CMP: begin
                if ($signed(mem_lat) < $signed(q_lat_reg)) begin
                    l_next = mid_reg;
                end else begin
                    r_next = {1'b0, mid_reg} - (AW+1)'(1);
                end
            end
            S_SW_LCAP: begin
                cl_lat_next = mem_lat;
                cl_lon_next = mem_lon;
            end
            S_SW_RCAP: begin
                cr_lat_next = mem_lat;
                cr_lon_next = mem_lon;
            end
            S_PICK: begin
                took_left_next = take_left;
                if (take_left) begin
                    p_lat_next = cl_lat_reg;
                    p_lon_next = cl_lon_reg;
                    p_pos_next = l_reg;
                    l_ok_next = (l_reg != '0);
                    l_next = l_reg - AW'(1);
                end else begin
                    p_lat_next = cr_lat_reg;
                    p_lon_next = cr_lon_reg;
                    p_pos_next = r_reg[AW-1:0];
                    r_next = r_reg + (AW+1)'(1);
                end
            end
            S_DIFF: begin
                da_next = abs_lat(p_lat_reg, q_lat_reg);
                db_next = abs_lon(p_lon_reg, q_lon_reg);
                // refill the side just taken
                if (!scan_reg && took_left_reg && l_ok_reg) begin
                    cl_lat_next = mem_lat;
                    cl_lon_next = mem_lon;
                end else if (!scan_reg && !took_left_reg && r_ok) begin
                    cr_lat_next = mem_lat;
                    cr_lon_next = mem_lon;
                end
            end
            S_SQ: begin
                sqa_next = da_reg * da_reg;
                sqb_next = db_reg * db_reg;
            end
            S_SUM: begin
                dist_next = {{(DIST_W-2*LAT_W){1'b0}}, sqa_reg}
                          + {{(DIST_W-2*LON_W){1'b0}}, sqb_reg};
            end
            S_INS: begin
                lcmd.insert = 1'b1;
                if (scan_reg) begin
                    l_next = l_reg + AW'(1);
                end
            end
            S_OUT_EMIT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next = M_DATA_W'({sat_dist, mem_lon, mem_lat, mem_tag});
                    m_tuser_next = 1'b1;
                    m_tlast_next = (list_kept == KW'(1));
                    lcmd.pop = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            ncount_reg <= CFG_W'(1);
            total_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) ncount_reg <= cfg_wdata;
            total_reg <= total_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        k_reg <= k_next;
        q_lat_reg <= q_lat_next;
        q_lon_reg <= q_lon_next;
        l_reg <= l_next;
        r_reg <= r_next;
        mid_reg <= mid_next;
        l_ok_reg <= l_ok_next;
        took_left_reg <= took_left_next;
        scan_reg <= scan_next;
        cl_lat_reg <= cl_lat_next;
        cl_lon_reg <= cl_lon_next;
        cr_lat_reg <= cr_lat_next;
        cr_lon_reg <= cr_lon_next;
        p_lat_reg <= p_lat_next;
        p_lon_reg <= p_lon_next;
        p_pos_reg <= p_pos_next;
        da_reg <= da_next;
        db_reg <= db_next;
        sqa_reg <= sqa_next;
        sqb_reg <= sqb_next;
        dist_reg <= dist_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
        m_tlast_reg <= m_tlast_next;
    end

    knnls_best_list #(
        .MAX_NEIGHBORS(MAX_NEIGHBORS),
        .POS_W(AW)
    ) u_best_list (
        .aclk(aclk),
        .aresetn(aresetn),
        .cmd(lcmd),
        .cap(k_reg),
        .new_dist(dist_reg),
        .new_pos(p_pos_reg),
        .kept(list_kept),
        .worst_dist(worst_dist),
        .head_dist(head_dist),
        .head_pos(head_pos)
    );

    a_total_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        total_reg <= (AW+1)'(MAX_POINTS))
        else $error("point count beyond capacity");

    a_kept_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_INS || state_reg == S_PICK || state_reg == S_OUT_RD) |->
        list_kept <= k_reg)
        else $error("kept list longer than k");

    a_mid_above_low: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_BS_CMP) |-> ({1'b0, mid_reg} > {1'b0, l_reg}) && ({1'b0, mid_reg} <= r_reg))
        else $error("search midpoint outside bounds");

    a_last_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_OUT_EMIT && out_free && list_kept == KW'(1)) |=>
        (list_kept == '0) && (state_reg == S_IDLE) && m_tlast_reg)
        else $error("final result left entries behind");

endmodule

`default_nettype wire

// File: sv/knnls_best_list.sv
`default_nettype none

module knnls_best_list
    import knnls_pkg::*;
#(
    parameter int MAX_NEIGHBORS = 16,
    parameter int POS_W = 10
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire list_cmd_t                             cmd,
    input  wire logic [$clog2(MAX_NEIGHBORS+1)-1:0]    cap,
    input  wire logic [DIST_W-1:0]                     new_dist,
    input  wire logic [POS_W-1:0]                      new_pos,
    output logic [$clog2(MAX_NEIGHBORS+1)-1:0]         kept,
    output logic [DIST_W-1:0]                          worst_dist,
    output logic [DIST_W-1:0]                          head_dist,
    output logic [POS_W-1:0]                           head_pos
);

    localparam int KW = $clog2(MAX_NEIGHBORS + 1);
    localparam int IW = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;

    logic [DIST_W-1:0] dist_reg [MAX_NEIGHBORS];
    logic [DIST_W-1:0] dist_next [MAX_NEIGHBORS];
    logic [POS_W-1:0]  pos_reg [MAX_NEIGHBORS];
    logic [POS_W-1:0]  pos_next [MAX_NEIGHBORS];
    logic [KW-1:0]     kept_reg;
    logic [KW-1:0]     kept_next;
    logic [MAX_NEIGHBORS-1:0] place;
    logic [IW-1:0]     worst_idx;
    logic [POS_W-1:0]  worst_pos;
    logic              accept;

    function automatic logic better(input logic [DIST_W-1:0] d1, input logic [POS_W-1:0] p1,
                                    input logic [DIST_W-1:0] d2, input logic [POS_W-1:0] p2);
        return (d1 < d2) || ((d1 == d2) && (p1 < p2));
    endfunction

    assign worst_idx  = IW'(kept_reg - KW'(1));
    assign worst_dist = dist_reg[worst_idx];
    assign worst_pos  = pos_reg[worst_idx];
    assign accept     = (kept_reg < cap) || better(new_dist, new_pos, worst_dist, worst_pos);
    assign kept       = kept_reg;
    assign head_dist  = dist_reg[0];
    assign head_pos   = pos_reg[0];

    // slot i and those after it move when the new word sorts ahead of entry i
    always_comb begin
        for (int i = 0; i < MAX_NEIGHBORS; i++) begin
            place[i] = !((KW'(i) < kept_reg) && !better(new_dist, new_pos, dist_reg[i], pos_reg[i]));
        end
    end

    always_comb begin
        for (int i = 0; i < MAX_NEIGHBORS; i++) begin
            dist_next[i] = dist_reg[i];
            pos_next[i]  = pos_reg[i];
        end
        kept_next = kept_reg;
        if (cmd.clear) begin
            kept_next = '0;
        end else if (cmd.pop) begin
            for (int i = 0; i + 1 < MAX_NEIGHBORS; i++) begin
                dist_next[i] = dist_reg[i+1];
                pos_next[i]  = pos_reg[i+1];
            end
            kept_next = kept_reg - KW'(1);
        end else if (cmd.insert && accept) begin
            if (place[0]) begin
                dist_next[0] = new_dist;
                pos_next[0]  = new_pos;
            end
            for (int i = 1; i < MAX_NEIGHBORS; i++) begin
                if (place[i] && !place[i-1]) begin
                    dist_next[i] = new_dist;
                    pos_next[i]  = new_pos;
                end else if (place[i]) begin
                    dist_next[i] = dist_reg[i-1];
                    pos_next[i]  = pos_reg[i-1];
                end
            end
            if (kept_reg < cap) begin
                kept_next = kept_reg + KW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < MAX_NEIGHBORS; i++) begin
            dist_reg[i] <= dist_next[i];
            pos_reg[i]  <= pos_next[i];
        end
        if (!aresetn) begin
            kept_reg <= '0;
        end else begin
            kept_reg <= kept_next;
        end
    end

endmodule

`default_nettype wire

// File: tb/sv/tb_knn_latitude_sweep_search.sv
`default_nettype none

module tb_knn_latitude_sweep_search;
    import knnls_pkg::*;

    localparam int NPTS = 1024;
    localparam int NBR  = 16;
    localparam longint unsigned SQD_MAX = (64'd1 << SQD_W) - 1;
    localparam int LAT_MAX = (1 << (LAT_W - 1)) - 1;
    localparam int LAT_MIN = -(1 << (LAT_W - 1));
    localparam int LON_MAX = (1 << (LON_W - 1)) - 1;
    localparam int LON_MIN = -(1 << (LON_W - 1));
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct {
        bit              found;
        bit [TAG_W-1:0]  tag;
        bit [LAT_W-1:0]  lat;
        bit [LON_W-1:0]  lon;
        bit [SQD_W-1:0]  sqd;
        bit              last;
    } neighbor_t;

    class knn_scoreboard;
        longint          pt_lat[NPTS];
        longint          pt_lon[NPTS];
        bit [TAG_W-1:0]  pt_tag[NPTS];
        int              pt_total;
        int              k_reg;
        longint unsigned kept_dist[NBR];
        int              kept_pos[NBR];
        int              kept_n;
        neighbor_t       nearest_q[$];
        int              errors;

        function void reset_state();
            pt_total = 0;
            k_reg = 1;
            errors = 0;
            nearest_q.delete();
        endfunction

        function void set_k(bit [CFG_W-1:0] v);
            k_reg = v;
        endfunction

        function void add_expected(neighbor_t e);
            nearest_q.insert(nearest_q.size(), e);
        endfunction

        function longint unsigned adiff(longint a, longint b);
            return (a >= b) ? longint'(a - b) : longint'(b - a);
        endfunction

        function bit closer(longint unsigned d1, int p1, longint unsigned d2, int p2);
            return d1 < d2 || (d1 == d2 && p1 < p2);
        endfunction

        function void keep(longint unsigned d, int pos, int cap);
            int i;
            if (kept_n >= cap) begin
                if (!closer(d, pos, kept_dist[cap-1], kept_pos[cap-1])) return;
                kept_n = cap - 1;
            end
            i = kept_n;
            while (i > 0 && closer(d, pos, kept_dist[i-1], kept_pos[i-1])) begin
                kept_dist[i] = kept_dist[i-1];
                kept_pos[i] = kept_pos[i-1];
                i--;
            end
            kept_dist[i] = d;
            kept_pos[i] = pos;
            kept_n++;
        endfunction

        function longint unsigned dist2(int t, longint qa, longint qo);
            longint unsigned a, b;
            a = adiff(pt_lat[t], qa);
            b = adiff(pt_lon[t], qo);
            return a * a + b * b;
        endfunction

        function void note_word(func_t f, bit [LAT_W-1:0] la, bit [LON_W-1:0] lo,
                                bit [TAG_W-1:0] tg);
            longint qa, qo;
            int k, n, l, r, mid, t;
            longint unsigned gap;
            neighbor_t e;
            qa = longint'(signed'(la));
            qo = longint'(signed'(lo));
            case (f)
                FUNC_CLEAR: pt_total = 0;
                FUNC_APPEND: begin
                    if (pt_total < NPTS) begin
                        pt_lat[pt_total] = qa;
                        pt_lon[pt_total] = qo;
                        pt_tag[pt_total] = tg;
                        pt_total++;
                    end
                end
                FUNC_QUERY: begin
                    n = pt_total;
                    if (n == 0) begin
                        e = '{0, 0, 0, 0, 0, 1};
                        add_expected(e);
                        return;
                    end
                    k = (k_reg < 1) ? 1 : (k_reg > NBR ? NBR : k_reg);
                    kept_n = 0;
                    if (n <= k) begin
                        for (int i = 0; i < n; i++) keep(dist2(i, qa, qo), i, k);
                    end else begin
                        l = 0;
                        r = n - 1;
                        while (l < r) begin
                            mid = (l + r + 1) / 2;
                            if (pt_lat[mid] < qa) l = mid;
                            else r = mid - 1;
                        end
                        r = l + 1;
                        while (l >= 0 || r < n) begin
                            if (r == n || (l >= 0 &&
                                adiff(pt_lat[l], qa) < adiff(pt_lat[r], qa))) begin
                                t = l;
                                l--;
                            end else begin
                                t = r;
                                r++;
                            end
                            gap = adiff(pt_lat[t], qa);
                            if (kept_n >= k && gap * gap >= kept_dist[kept_n-1]) break;
                            keep(dist2(t, qa, qo), t, k);
                        end
                    end
                    for (int i = 0; i < kept_n; i++) begin
                        e.found = 1;
                        e.tag = pt_tag[kept_pos[i]];
                        e.lat = pt_lat[kept_pos[i]][LAT_W-1:0];
                        e.lon = pt_lon[kept_pos[i]][LON_W-1:0];
                        e.sqd = (kept_dist[i] > SQD_MAX) ? SQD_W'(SQD_MAX)
                                                         : kept_dist[i][SQD_W-1:0];
                        e.last = (i + 1 == kept_n);
                        add_expected(e);
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_result(neighbor_t a);
            neighbor_t e;
            if (nearest_q.size() == 0) begin
                $error("unexpected result word tag=%h", a.tag);
                errors++;
                return;
            end
            e = nearest_q.pop_front();
            if (a.found != e.found) begin
                $error("found exp %0d act %0d", e.found, a.found); errors++;
            end
            if (a.tag != e.tag) begin
                $error("neighbor_tag exp %h act %h", e.tag, a.tag); errors++;
            end
            if (a.lat != e.lat) begin
                $error("neighbor_latitude exp %h act %h", e.lat, a.lat); errors++;
            end
            if (a.lon != e.lon) begin
                $error("neighbor_longitude exp %h act %h", e.lon, a.lon); errors++;
            end
            if (a.sqd != e.sqd) begin
                $error("squared_distance exp %h act %h", e.sqd, a.sqd); errors++;
            end
            if (a.last != e.last) begin
                $error("last exp %0d act %0d", e.last, a.last); errors++;
            end
        endfunction
    endclass

    logic                 aclk = 0;
    logic                 aresetn = 0;
    logic                 cfg_we = 0;
    logic [CFG_W-1:0]     cfg_wdata = '0;
    logic                 s_tvalid = 0;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata = '0;
    logic [FUNC_W-1:0]    s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 0;
    logic [M_DATA_W-1:0]  m_tdata;
    logic                 m_tuser;
    logic                 m_tlast;

    knn_latitude_sweep_search dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast)
    );

    always begin
        #10 aclk = 1;
        #10 aclk = 0;
    end

    knn_scoreboard nn_board = new();
    bit  calm = 1;
    int  hold_req = 0;
    int  hold_left = 0;
    int  cycles = 0;

    // receiver
    always @(posedge aclk) begin
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 0;
        end else begin
            m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 27);
        end
    end

    // monitor
    always @(posedge aclk) begin
        neighbor_t got;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
        if (aresetn) begin
            if (s_tvalid && s_tready)
                nn_board.note_word(func_t'(s_tuser), s_tdata[27:0], s_tdata[56:28],
                                   s_tdata[88:57]);
            if (m_tvalid && m_tready) begin
                got.found = m_tuser;
                got.tag = m_tdata[31:0];
                got.lat = m_tdata[59:32];
                got.lon = m_tdata[88:60];
                got.sqd = m_tdata[146:89];
                got.last = m_tlast;
                nn_board.check_result(got);
            end
        end
    end

    task automatic send(func_t f, int la, int lo, bit [TAG_W-1:0] tg);
        while (!calm && $urandom_range(99) < 27) begin
            s_tvalid <= 0;
            @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tuser <= f;
        s_tdata <= {7'd0, tg, lo[LON_W-1:0], la[LAT_W-1:0]};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic drain();
        s_tvalid <= 0;
        @(posedge aclk);
        while (nn_board.nearest_q.size() > 0 || !s_tready || m_tvalid) @(posedge aclk);
        repeat (30) @(posedge aclk);
    endtask

    task automatic write_k(bit [CFG_W-1:0] v);
        drain();
        cfg_we <= 1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 0;
        nn_board.set_k(v);
    endtask

    function automatic int rand_lat();
        return $urandom_range(1) ? int'($urandom_range(0, 2 * LAT_MAX + 1)) + LAT_MIN
                                 : int'($urandom_range(0, 2000)) - 1000;
    endfunction

    function automatic int rand_lon();
        return $urandom_range(1) ? int'($urandom_range(0, 2 * LON_MAX + 1)) + LON_MIN
                                 : int'($urandom_range(0, 2000)) - 1000;
    endfunction

    // clear and load a sorted list of n points
    task automatic load_sorted(int n, int step_max);
        longint la;
        send(FUNC_CLEAR, rand_lat(), rand_lon(), $urandom);
        la = (step_max > 100) ? rand_lat() - longint'(n) * step_max / 2
                              : int'($urandom_range(0, 2000)) - 1000;
        if (la < LAT_MIN) la = LAT_MIN;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(9) == 0)
                send(FUNC_NONE, rand_lat(), rand_lon(), $urandom);
            send(FUNC_APPEND, int'(la), rand_lon(), $urandom);
            la += $urandom_range(0, step_max);
            if (la > LAT_MAX) la = LAT_MAX;
        end
    endtask

    initial begin
        int sent;
        int sizes;
        nn_board.reset_state();
        repeat (9) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: empty list, extremes, saturation, ties, ignored code
        send(FUNC_QUERY, 0, 0, 0);
        send(FUNC_APPEND, LAT_MIN, LON_MIN, 32'h0);
        send(FUNC_QUERY, LAT_MAX, LON_MAX, 0);
        send(FUNC_NONE, 5, 5, 32'h1234);
        send(FUNC_APPEND, 0, 0, 32'hffff_ffff);
        send(FUNC_APPEND, LAT_MAX, LON_MAX, 32'h5555_aaaa);
        send(FUNC_QUERY, 0, 0, 0);
        send(FUNC_QUERY, LAT_MIN, LON_MAX, 0);
        write_k(16);
        send(FUNC_QUERY, LAT_MAX, LON_MIN, 0);
        send(FUNC_CLEAR, 0, 0, 0);
        send(FUNC_QUERY, 1, 1, 0);
        for (int i = 0; i < 5; i++) send(FUNC_APPEND, 10, 10, 32'h100 + i);
        send(FUNC_QUERY, 10, 10, 0);
        write_k(0);
        send(FUNC_QUERY, 10, 13, 0);
        write_k(2);
        send(FUNC_APPEND, 20, 0, 32'h200);
        send(FUNC_QUERY, 15, 10, 0);
        send(FUNC_QUERY, 10, 10, 0);
        write_k(31);
        send(FUNC_QUERY, -7, 3, 0);

        // random phases
        calm = 0;
        sent = 0;
        while (sent < 285) begin
            case ($urandom_range(5))
                0: write_k(1);
                1: write_k(16);
                default: write_k(CFG_W'($urandom_range(0, 31)));
            endcase
            if (sent > 100 && sent < 140) calm = 1;
            else calm = 0;
            if (sent > 150 && sent < 200) hold_req = 400;
            sizes = ($urandom_range(7) == 0) ? $urandom_range(40, 120) : $urandom_range(0, 24);
            load_sorted(sizes, $urandom_range(1) ? 50 : 3000000);
            sent += sizes + 1;
            for (int i = 0; i < $urandom_range(2, 8); i++) begin
                if ($urandom_range(15) == 0)
                    send(FUNC_APPEND, rand_lat(), rand_lon(), $urandom);
                send(FUNC_QUERY, rand_lat(), rand_lon(), 0);
                sent++;
            end
        end
        drain();
        if (nn_board.errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: files.f
sv/knnls_pkg.sv
sv/knnls_best_list.sv
sv/knn_latitude_sweep_search.sv
tb/sv/tb_knn_latitude_sweep_search.sv
